// File: sv/cpr_pkg.sv
// Package for the clock page replacement block: sizes, opcodes, FSM states,
// transfer payload structs and the ring wrap helper. No dependencies.
package cpr_pkg;

    localparam int SLOTS      = 16;
    localparam int FRAME_BITS = 8;
    localparam int SLOT_BITS  = 4;
    localparam int COUNT_BITS = 5;
    localparam int APB_AW     = 2;
    localparam int APB_DW     = 32;

    // Register map, byte addresses
    localparam logic [APB_AW-1:0] REG_SLOTS_IN_USE = 2'd0;

    typedef enum logic [1:0] {
        OP_REFERENCE = 2'd0,
        OP_FILL      = 2'd1,
        OP_VICTIM    = 2'd2,
        OP_NONE      = 2'd3
    } cpr_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FETCH,
        ST_RESULT
    } cpr_state_t;

    typedef struct packed {
        logic [1:0]            opcode;
        logic [SLOT_BITS-1:0]  slot_index;
        logic [FRAME_BITS-1:0] frame_number;
    } in_item_t;

    typedef struct packed {
        logic                  victim_found;
        logic [SLOT_BITS-1:0]  victim_slot;
        logic [FRAME_BITS-1:0] victim_frame;
    } out_item_t;

    // Step the hand one slot, wrapping at the ring size
    function automatic logic [SLOT_BITS-1:0] next_slot(
        input logic [SLOT_BITS-1:0]  pos,
        input logic [COUNT_BITS-1:0] ring_n
    );
        logic [COUNT_BITS-1:0] sum;
        sum = {{(COUNT_BITS-SLOT_BITS){1'b0}}, pos} + COUNT_BITS'(1);
        return (sum >= ring_n) ? '0 : sum[SLOT_BITS-1:0];
    endfunction

endpackage

// File: sv/clock_page_replacement.sv
// Top level of the second-chance clock replacement block.
// Depends on cpr_pkg and cpr_frame_store.

// One item is taken at a time. A reference, a fill or an unused opcode goes
// from transfer to the result state and then to the output register. A victim
// request passes p slots with their use bit set, where p runs from 0 to the
// ring size; the scan looks at one use bit per cycle starting at the hand,
// then the frame memory is read through the fetch state. The result
// sits in an output register, so the next item is taken as soon as the
// result is loaded, whether or not it has been taken yet. slots_in_use is at
// byte address 0; a value of 0 acts as 1 and one above 16 acts as 16.
module clock_page_replacement (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input item channel
    input  logic                           s_valid,
    output logic                           s_ready,
    input  cpr_pkg::in_item_t              s_item,
    // result channel
    output logic                           m_valid,
    input  logic                           m_ready,
    output cpr_pkg::out_item_t             m_item,
    // configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [cpr_pkg::APB_AW-1:0]     paddr,
    input  logic [cpr_pkg::APB_DW-1:0]     pwdata,
    output logic [cpr_pkg::APB_DW-1:0]     prdata,
    output logic                           pready
);

    cpr_pkg::cpr_state_t                  state_reg, state_next;
    logic [cpr_pkg::SLOT_BITS-1:0]        hand_reg, hand_next;
    logic [cpr_pkg::SLOT_BITS-1:0]        pos_reg, pos_next;
    logic [cpr_pkg::SLOTS-1:0]            use_reg, use_next;
    logic                                 found_reg, found_next;
    logic [cpr_pkg::COUNT_BITS-1:0]       slots_reg;
    logic                                 m_valid_reg, m_valid_next;
    cpr_pkg::out_item_t                   m_item_reg, m_item_next;

    logic                                 s_xfer;
    logic                                 out_free;
    logic [cpr_pkg::COUNT_BITS-1:0]       ring_n;
    logic [cpr_pkg::SLOT_BITS-1:0]        start_pos;
    logic                                 mem_we;
    logic                                 mem_re;
    logic [cpr_pkg::FRAME_BITS-1:0]       mem_rdata;

    // Configuration port
    assign pready = 1'b1;
    assign prdata = {{(cpr_pkg::APB_DW-cpr_pkg::COUNT_BITS){1'b0}}, slots_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slots_reg <= cpr_pkg::COUNT_BITS'(cpr_pkg::SLOTS);
        end else if (psel && penable && pwrite && pready
                     && paddr == cpr_pkg::REG_SLOTS_IN_USE) begin
            slots_reg <= pwdata[cpr_pkg::COUNT_BITS-1:0];
        end
    end

    // Clamp the ring size and the scan start
    always_comb begin
        if (slots_reg == '0) begin
            ring_n = cpr_pkg::COUNT_BITS'(1);
        end else if (slots_reg > cpr_pkg::COUNT_BITS'(cpr_pkg::SLOTS)) begin
            ring_n = cpr_pkg::COUNT_BITS'(cpr_pkg::SLOTS);
        end else begin
            ring_n = slots_reg;
        end
        start_pos = ({1'b0, hand_reg} >= ring_n) ? '0 : hand_reg;
    end

    assign s_xfer   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            cpr_pkg::ST_IDLE: begin
                if (s_xfer) begin
                    state_next = (s_item.opcode == cpr_pkg::OP_VICTIM)
                               ? cpr_pkg::ST_SCAN : cpr_pkg::ST_RESULT;
                end
            end
            cpr_pkg::ST_SCAN: begin
                if (!use_reg[pos_reg]) begin
                    state_next = cpr_pkg::ST_FETCH;
                end
            end
            cpr_pkg::ST_FETCH: begin
                state_next = cpr_pkg::ST_RESULT;
            end
            cpr_pkg::ST_RESULT: begin
                if (out_free) begin
                    state_next = cpr_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = cpr_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath
    always_comb begin
        s_ready      = 1'b0;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        hand_next    = hand_reg;
        pos_next     = pos_reg;
        use_next     = use_reg;
        found_next   = found_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_item_next  = m_item_reg;
        case (state_reg)
            cpr_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_xfer) begin
                    found_next = 1'b0;
                    case (s_item.opcode)
                        cpr_pkg::OP_REFERENCE: begin
                            use_next[s_item.slot_index] = 1'b1;
                        end
                        cpr_pkg::OP_FILL: begin
                            use_next[s_item.slot_index] = 1'b1;
                            mem_we = 1'b1;
                        end
                        cpr_pkg::OP_VICTIM: begin
                            pos_next = start_pos;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            cpr_pkg::ST_SCAN: begin
                // Give a second chance, or take this slot
                if (use_reg[pos_reg]) begin
                    use_next[pos_reg] = 1'b0;
                    pos_next = cpr_pkg::next_slot(pos_reg, ring_n);
                end else begin
                    found_next = 1'b1;
                    mem_re     = 1'b1;
                    hand_next  = cpr_pkg::next_slot(pos_reg, ring_n);
                end
            end
            cpr_pkg::ST_FETCH: begin
            end
            cpr_pkg::ST_RESULT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (found_reg) begin
                        m_item_next.victim_found = 1'b1;
                        m_item_next.victim_slot  = pos_reg;
                        m_item_next.victim_frame = mem_rdata;
                    end else begin
                        m_item_next = '0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= cpr_pkg::ST_IDLE;
            hand_reg    <= '0;
            use_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            hand_reg    <= hand_next;
            use_reg     <= use_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        pos_reg    <= pos_next;
        found_reg  <= found_next;
        m_item_reg <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    cpr_frame_store u_store (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (s_item.slot_index),
        .wdata (s_item.frame_number),
        .re    (mem_re),
        .raddr (pos_reg),
        .rdata (mem_rdata)
    );

endmodule

// File: sv/cpr_frame_store.sv
// Frame number store: one synchronous memory, one write and one read port,
// read data registered. Depends on cpr_pkg.
module cpr_frame_store (
    input  logic                           aclk,
    input  logic                           we,
    input  logic [cpr_pkg::SLOT_BITS-1:0]  waddr,
    input  logic [cpr_pkg::FRAME_BITS-1:0] wdata,
    input  logic                           re,
    input  logic [cpr_pkg::SLOT_BITS-1:0]  raddr,
    output logic [cpr_pkg::FRAME_BITS-1:0] rdata
);

    logic [cpr_pkg::FRAME_BITS-1:0] mem [cpr_pkg::SLOTS];

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: sv/cpr_checker.sv
// Port-level checker for clock_page_replacement, attached by bind.
// Depends on cpr_pkg.
module cpr_checker (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_valid,
    input logic                   s_ready,
    input logic                   m_valid,
    input logic                   m_ready,
    input cpr_pkg::out_item_t     m_item,
    input logic                   pready
);

    // Hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result changed while stalled");

    // Zero the slot and frame when no victim is carried
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_item.victim_found |->
            m_item.victim_slot == '0 && m_item.victim_frame == '0)
        else $error("non-victim result carries data");

    // One item in flight: no transfer right after a transfer
    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while an item is in flight");

    // Configuration port never waits
    a_pready: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("pready dropped");

endmodule

bind clock_page_replacement cpr_checker u_cpr_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item),
    .pready  (pready)
);
